FILE: src/sctvc_pkg.sv
package sctvc_pkg;

    // Array geometry (CELLS must be a power of two)
    localparam int CELLS    = 1024;
    localparam int CHANNELS = 4;
    localparam int CELL_W   = $clog2(CELLS);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field and accumulator widths
    localparam int MASK_W   = 4;
    localparam int SUM_W    = 33;
    localparam int TIME_W   = 36;
    localparam int CELLREQ_W = 10;
    localparam int WIDTH_W  = 22;
    localparam int RC_W     = 11;
    localparam int ADC_W    = 16;
    localparam int UV_W     = 22;

    // Request queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // adc * 1e6 / 65535 = 15 * adc + (16975 * adc) / 65535
    localparam int VOLT_HI     = 15;
    localparam int VOLT_LO     = 16975;
    localparam int ROUND_BIAS  = 32767;
    localparam int CODE_FULL   = 65535;
    localparam int UV_PER_MV   = 1000;
    localparam int UV_OFFSET   = 500000;
    localparam int VOLT_Z_W    = 31;
    localparam int VOLT_Q_W    = 20;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_START,
        CMD_SAMPLE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic [CH_IDX_W-1:0]         ch;
        logic [CELLREQ_W-1:0]        pos;
        logic [WIDTH_W-1:0]          width;
        logic [CELL_W-1:0]           trig;
        logic signed [RC_W-1:0]      rc;
        logic [ADC_W-1:0]            adc;
    } cmd_t;

endpackage

FILE: src/sctvc_front.sv
module sctvc_front import sctvc_pkg::*; (
    input  logic [1:0]             s_opcode,
    input  logic [1:0]             s_channel,
    input  logic [CELLREQ_W-1:0]   s_cell_req,
    input  logic [WIDTH_W-1:0]     s_cell_width_fs,
    input  logic [CELLREQ_W-1:0]   s_trigger_cell,
    input  logic signed [RC_W-1:0] s_range_center_mv,
    input  logic [ADC_W-1:0]       s_adc_code,
    output cmd_t                   cmd,
    output logic                   keep
);

    logic ch_ok;
    logic cell_ok;

    assign ch_ok   = int'(s_channel) < CHANNELS;
    assign cell_ok = int'(s_cell_req) < CELLS;

    always_comb begin
        cmd.ch    = CH_IDX_W'(s_channel);
        cmd.pos   = s_cell_req;
        cmd.width = s_cell_width_fs;
        // power-of-two array: truncation is the modulo
        cmd.trig  = CELL_W'(s_trigger_cell);
        cmd.rc    = s_range_center_mv;
        cmd.adc   = s_adc_code;
        unique case (s_opcode)
            OP_LOAD: begin
                cmd.kind = CMD_LOAD;
                keep     = ch_ok && cell_ok;
            end
            OP_START: begin
                cmd.kind = CMD_START;
                keep     = 1'b1;
            end
            OP_SAMPLE: begin
                cmd.kind = CMD_SAMPLE;
                keep     = ch_ok && cell_ok;
            end
            default: begin
                cmd.kind = CMD_LOAD;
                keep     = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/sctvc_fifo.sv
module sctvc_fifo import sctvc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;

    assign full     = count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/sctvc_back.sv
module sctvc_back import sctvc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [MASK_W-1:0]       enable_mask,
    input  cmd_t                    head,
    input  logic                    head_valid,
    output logic                    head_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_out_channel,
    output logic [CELLREQ_W-1:0]    m_out_index,
    output logic signed [TIME_W-1:0] m_time_fs,
    output logic signed [UV_W-1:0]  m_voltage_uv
);

    localparam logic signed [23:0] UV_SCALE = 24'(UV_PER_MV);
    localparam logic signed [23:0] UV_BIAS  = 24'(UV_OFFSET);

    logic adv;

    // architectural state
    logic [SUM_W-1:0]       run_reg, run_next;
    logic [SUM_W-1:0]       totals_reg [CHANNELS];
    logic [SUM_W-1:0]       sp_reg     [CHANNELS];
    logic [TIME_W-1:0]      off_reg    [CHANNELS];
    logic [CELL_W-1:0]      trig_reg;
    logic signed [RC_W-1:0] rc_reg;

    // stage A (queue head)
    logic                   is_load, is_start, is_sample;
    logic [CELL_W:0]        idx_sum;
    logic                   idx_wrap;
    logic [CELL_W-1:0]      rd_addr;
    logic [CELL_W-1:0]      wr_addr;
    logic [SUM_W-1:0]       wr_data;
    logic [SUM_W-1:0]       rd_q [CHANNELS];

    // stage B
    logic                   b_valid_reg;
    cmd_kind_t              b_kind_reg;
    logic [CH_IDX_W-1:0]    b_ch_reg;
    logic [CELLREQ_W-1:0]   b_index_reg;
    logic                   b_wrap_reg;
    logic                   b_tzero_reg;
    logic signed [RC_W-1:0] b_rc_reg;
    logic [VOLT_Z_W-1:0]    b_z_reg;
    logic [VOLT_Q_W-1:0]    b_m15_reg;
    logic [TIME_W-1:0]      b_sum;
    logic [16:0]            b_frac;
    logic [VOLT_Q_W-1:0]    b_q;
    logic [TIME_W-1:0]      reftime_next [CHANNELS];

    // stage C
    logic                   c_valid_reg;
    cmd_kind_t              c_kind_reg;
    logic [CH_IDX_W-1:0]    c_ch_reg;
    logic [CELLREQ_W-1:0]   c_index_reg;
    logic [TIME_W-1:0]      c_sum_reg;
    logic [VOLT_Q_W-1:0]    c_q_reg;
    logic signed [RC_W-1:0] c_rc_reg;
    logic [TIME_W-1:0]      reftime_reg [CHANNELS];
    logic [CHANNELS-1:0]    ch_en;
    logic [CH_IDX_W-1:0]    ref_ch;
    logic                   any_en;
    logic [TIME_W-1:0]      off_next [CHANNELS];
    logic [TIME_W-1:0]      c_time;
    logic signed [23:0]     rc_wide;
    logic signed [23:0]     uv_wide;

    // output register
    logic                   m_valid_reg;

    assign adv      = !m_valid_reg || m_ready;
    assign head_pop = adv && head_valid;
    assign m_valid  = m_valid_reg;

    assign is_load   = head_pop && (head.kind == CMD_LOAD);
    assign is_start  = head_pop && (head.kind == CMD_START);
    assign is_sample = head_pop && (head.kind == CMD_SAMPLE);

    // ---------------- stage A: address, table write ----------------
    always_comb begin
        idx_sum  = {1'b0, trig_reg} + {1'b0, CELL_W'(head.pos)};
        idx_wrap = idx_sum >= (CELL_W+1)'(CELLS);
        if (head.kind == CMD_START) begin
            rd_addr = head.trig;
        end else if (idx_wrap) begin
            rd_addr = CELL_W'(idx_sum - (CELL_W+1)'(CELLS));
        end else begin
            rd_addr = CELL_W'(idx_sum);
        end
        wr_addr  = CELL_W'(head.pos);
        // cell 0 restarts the running sum
        wr_data  = (head.pos == '0) ? '0 : run_reg;
        run_next = wr_data + SUM_W'(head.width);
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_bank
        logic [SUM_W-1:0] mem [CELLS];

        always_ff @(posedge aclk) begin
            if (is_load && (head.ch == CH_IDX_W'(g))) begin
                mem[wr_addr] <= wr_data;
            end
            if (adv) begin
                rd_q[g] <= mem[rd_addr];
            end
        end

        assign ch_en[g] = (g < MASK_W) ? enable_mask[g % MASK_W] : 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= '0;
            trig_reg <= '0;
            rc_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                totals_reg[c] <= '0;
            end
        end else begin
            if (is_load) begin
                run_reg              <= run_next;
                totals_reg[head.ch]  <= run_next;
            end
            if (is_start) begin
                trig_reg <= head.trig;
                rc_reg   <= head.rc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= is_start || is_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_kind_reg  <= head.kind;
            b_ch_reg    <= head.ch;
            b_index_reg <= head.pos;
            b_wrap_reg  <= idx_wrap;
            b_tzero_reg <= head.trig == '0;
            b_rc_reg    <= rc_reg;
            b_z_reg     <= VOLT_Z_W'(head.adc) * VOLT_Z_W'(VOLT_LO) + VOLT_Z_W'(ROUND_BIAS);
            b_m15_reg   <= VOLT_Q_W'(head.adc) * VOLT_Q_W'(VOLT_HI);
        end
    end

    // ---------------- stage B: prefix differences ----------------
    always_comb begin
        b_sum  = (b_wrap_reg ? TIME_W'(totals_reg[b_ch_reg]) : '0)
               + TIME_W'(rd_q[b_ch_reg]) - TIME_W'(sp_reg[b_ch_reg]);
        // z / 65535 with z < 2^31: high half plus one carry step
        b_frac = 17'(b_z_reg[VOLT_Z_W-1:16]) + 17'(b_z_reg[15:0]);
        b_q    = b_m15_reg + VOLT_Q_W'(b_z_reg[VOLT_Z_W-1:16])
               + VOLT_Q_W'(b_frac >= 17'(CODE_FULL));
        for (int c = 0; c < CHANNELS; c++) begin
            reftime_next[c] = b_tzero_reg ? '0
                            : TIME_W'(totals_reg[c]) - TIME_W'(rd_q[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                sp_reg[c] <= '0;
            end
        end else if (adv && b_valid_reg && (b_kind_reg == CMD_START)) begin
            for (int c = 0; c < CHANNELS; c++) begin
                sp_reg[c] <= rd_q[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_kind_reg  <= b_kind_reg;
            c_ch_reg    <= b_ch_reg;
            c_index_reg <= b_index_reg;
            c_sum_reg   <= b_sum;
            c_q_reg     <= b_q;
            c_rc_reg    <= b_rc_reg;
            for (int c = 0; c < CHANNELS; c++) begin
                reftime_reg[c] <= reftime_next[c];
            end
        end
    end

    // ---------------- stage C: alignment, voltage ----------------
    always_comb begin
        ref_ch = '0;
        any_en = |ch_en;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (ch_en[c]) begin
                ref_ch = CH_IDX_W'(c);
            end
        end
        for (int c = 0; c < CHANNELS; c++) begin
            off_next[c] = (any_en && ch_en[c]) ? reftime_reg[c] - reftime_reg[ref_ch] : '0;
        end
        c_time  = c_sum_reg - off_reg[c_ch_reg];
        rc_wide = 24'(c_rc_reg);
        uv_wide = $signed({4'b0, c_q_reg}) + rc_wide * UV_SCALE - UV_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                off_reg[c] <= '0;
            end
        end else if (adv && c_valid_reg && (c_kind_reg == CMD_START)) begin
            for (int c = 0; c < CHANNELS; c++) begin
                off_reg[c] <= off_next[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= c_valid_reg && (c_kind_reg == CMD_SAMPLE);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && c_valid_reg && (c_kind_reg == CMD_SAMPLE)) begin
            m_out_channel <= 2'(c_ch_reg);
            m_out_index   <= c_index_reg;
            m_time_fs     <= $signed(c_time);
            m_voltage_uv  <= UV_W'(uv_wide);
        end
    end

endmodule

FILE: src/sampling_cell_time_voltage_calib.sv
// Time and voltage calibration for a switched-capacitor sampling array.
// Requests enter on the s_ channel (valid/ready) and are one of: load cell
// width (cells of a channel in order, starting at cell 0), start event
// (trigger cell and range centre), or waveform sample. Each sample request
// yields one result on the m_ channel: aligned time in fs, relative to the
// lowest channel enabled in channel_enable_mask, and voltage in uV. Loads,
// starts, bad channels, positions past the array and opcode 3 give no
// result. The block sustains one request per clock unless m_ready stalls;
// a sample passes from the four-entry request queue through the registered
// prefix-sum table read and two add stages. The user must write the enable
// mask through cfg_wr_en / cfg_wr_data only while no request is in flight;
// the block does not enforce it. The prefix-sum table is not cleared by
// reset: a sample must only address cells already loaded.
module sampling_cell_time_voltage_calib import sctvc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [MASK_W-1:0]        cfg_wr_data,
    // request channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_opcode,
    input  logic [1:0]               s_channel,
    input  logic [CELLREQ_W-1:0]     s_cell_req,
    input  logic [WIDTH_W-1:0]       s_cell_width_fs,
    input  logic [CELLREQ_W-1:0]     s_trigger_cell,
    input  logic signed [RC_W-1:0]   s_range_center_mv,
    input  logic [ADC_W-1:0]         s_adc_code,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_out_channel,
    output logic [CELLREQ_W-1:0]     m_out_index,
    output logic signed [TIME_W-1:0] m_time_fs,
    output logic signed [UV_W-1:0]   m_voltage_uv
);

    logic [MASK_W-1:0] channel_enable_mask_reg;

    cmd_t front_cmd;
    logic front_keep;
    logic fifo_full;
    logic fifo_empty;
    logic fifo_push;
    logic fifo_pop;
    cmd_t fifo_head;

    // enable mask; the lowest set bit picks the timing reference
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_enable_mask_reg <= '0;
        end else if (cfg_wr_en) begin
            channel_enable_mask_reg <= cfg_wr_data;
        end
    end

    // accept whenever the queue has room; requests that do nothing are
    // accepted and dropped here
    assign s_ready   = !fifo_full;
    assign fifo_push = s_valid && s_ready && front_keep;

    sctvc_front u_front (
        .s_opcode          (s_opcode),
        .s_channel         (s_channel),
        .s_cell_req        (s_cell_req),
        .s_cell_width_fs   (s_cell_width_fs),
        .s_trigger_cell    (s_trigger_cell),
        .s_range_center_mv (s_range_center_mv),
        .s_adc_code        (s_adc_code),
        .cmd               (front_cmd),
        .keep              (front_keep)
    );

    // decouples intake from the calibration pipeline
    sctvc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (front_cmd),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (fifo_head),
        .empty     (fifo_empty)
    );

    // table, event state and arithmetic; stalls as a whole on m_ready
    sctvc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .enable_mask   (channel_enable_mask_reg),
        .head          (fifo_head),
        .head_valid    (!fifo_empty),
        .head_pop      (fifo_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_out_index   (m_out_index),
        .m_time_fs     (m_time_fs),
        .m_voltage_uv  (m_voltage_uv)
    );

endmodule

FILE: src/sctvc_checker.sv
module sctvc_checker import sctvc_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [1:0]               m_out_channel,
    input logic [CELLREQ_W-1:0]     m_out_index,
    input logic signed [TIME_W-1:0] m_time_fs,
    input logic signed [UV_W-1:0]   m_voltage_uv
);

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // empty queue out of reset takes requests
    a_ready_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("not ready after reset");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_time_fs) && $stable(m_voltage_uv)
            && $stable(m_out_index) && $stable(m_out_channel))
        else $error("stalled result changed");

    // voltage stays within the span of code and range centre
    a_uv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_voltage_uv >= -22'sd1524000) && (m_voltage_uv <= 22'sd1523000))
        else $error("voltage out of range");

    // results only for channels and positions that exist
    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_out_index) < CELLS) && (int'(m_out_channel) < CHANNELS))
        else $error("result for missing channel or cell");

endmodule

bind sampling_cell_time_voltage_calib sctvc_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_channel (m_out_channel),
    .m_out_index   (m_out_index),
    .m_time_fs     (m_time_fs),
    .m_voltage_uv  (m_voltage_uv)
);
